FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the register access unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, switched off while reset is high.
`define SCCB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication built on the plain form.
`define SCCB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  `SCCB_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

`endif

FILE: sv/sccb_pkg.sv
// ----------------------------------------------------------------------------
// SCCB register access package
// Item types, codes and the phase programme of the bit-level sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sccb_pkg;

  // Input item opcodes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_PHASE_TICKS    = 1'b1;

  localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'd66;
  localparam logic [15:0] PHASE_TICKS_RESET    = 16'd50;
  localparam logic [7:0]  READ_BIT             = 8'h01;

  // Sequencer steps.
  localparam logic [5:0] STEP_WRITE = 6'd0;
  localparam logic [5:0] STEP_READ  = 6'd21;
  localparam logic [5:0] STEP_COUNT = 6'd58;
  localparam logic [5:0] STEP_IDLE  = 6'd63;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Line levels as {scl, sda, enable}; idle is both lines high and driven.
  localparam logic [2:0] LINES_IDLE = 3'b111;

  // Command queue depth.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } sccb_in_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic [7:0] read_data;
  } sccb_out_t;

  // Classified item as held in the queue.
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_WRITE,
    KIND_READ,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } sccb_cmd_t;

  // Source of the SDA level within a phase.
  typedef enum logic [1:0] {
    SDA_LO,
    SDA_HI,
    SDA_BIT
  } sda_src_t;

  // Byte loaded into the shifter on entering a phase.
  typedef enum logic [2:0] {
    LOAD_NONE,
    LOAD_ID,
    LOAD_IDR,
    LOAD_REG,
    LOAD_DATA
  } load_t;

  // Action at the end of a phase.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ACK,
    ACT_LOOPW,
    ACT_SAMPLE,
    ACT_LOOPR,
    ACT_FIN
  } act_t;

  typedef struct packed {
    logic     scl;
    sda_src_t sda;
    logic     oe;
    load_t    load;
    act_t     act;
  } phase_row_t;

  localparam phase_row_t ROW_ST0 = '{scl: 1'b1, sda: SDA_HI, oe: 1'b1,
                                     load: LOAD_NONE, act: ACT_NONE};
  localparam phase_row_t ROW_ST1 = '{scl: 1'b1, sda: SDA_LO, oe: 1'b1,
                                     load: LOAD_NONE, act: ACT_NONE};
  localparam phase_row_t ROW_ALO = '{scl: 1'b0, sda: SDA_HI, oe: 1'b0,
                                     load: LOAD_NONE, act: ACT_NONE};
  localparam phase_row_t ROW_AHI = '{scl: 1'b1, sda: SDA_HI, oe: 1'b0,
                                     load: LOAD_NONE, act: ACT_ACK};
  localparam phase_row_t ROW_GLO = '{scl: 1'b0, sda: SDA_HI, oe: 1'b1,
                                     load: LOAD_NONE, act: ACT_NONE};
  localparam phase_row_t ROW_GHI = '{scl: 1'b1, sda: SDA_HI, oe: 1'b1,
                                     load: LOAD_NONE, act: ACT_NONE};
  localparam phase_row_t ROW_BHI = '{scl: 1'b1, sda: SDA_BIT, oe: 1'b1,
                                     load: LOAD_NONE, act: ACT_LOOPW};
  localparam phase_row_t ROW_SP0 = '{scl: 1'b0, sda: SDA_LO, oe: 1'b1,
                                     load: LOAD_NONE, act: ACT_NONE};
  localparam phase_row_t ROW_SP1 = '{scl: 1'b1, sda: SDA_LO, oe: 1'b1,
                                     load: LOAD_NONE, act: ACT_NONE};
  localparam phase_row_t ROW_SP2 = '{scl: 1'b1, sda: SDA_HI, oe: 1'b1,
                                     load: LOAD_NONE, act: ACT_FIN};
  localparam phase_row_t ROW_BID = '{scl: 1'b0, sda: SDA_BIT, oe: 1'b1,
                                     load: LOAD_ID, act: ACT_NONE};
  localparam phase_row_t ROW_BIR = '{scl: 1'b0, sda: SDA_BIT, oe: 1'b1,
                                     load: LOAD_IDR, act: ACT_NONE};
  localparam phase_row_t ROW_BRG = '{scl: 1'b0, sda: SDA_BIT, oe: 1'b1,
                                     load: LOAD_REG, act: ACT_NONE};
  localparam phase_row_t ROW_BDT = '{scl: 1'b0, sda: SDA_BIT, oe: 1'b1,
                                     load: LOAD_DATA, act: ACT_NONE};
  localparam phase_row_t ROW_RLO = '{scl: 1'b0, sda: SDA_HI, oe: 1'b0,
                                     load: LOAD_NONE, act: ACT_SAMPLE};
  localparam phase_row_t ROW_RHI = '{scl: 1'b1, sda: SDA_HI, oe: 1'b0,
                                     load: LOAD_NONE, act: ACT_LOOPR};

  // Phase programme: steps 0 to 20 write a register, 21 to 57 read one.
  function automatic phase_row_t phase_row(input logic [5:0] step);
    phase_row_t row;
    unique case (step)
      6'd0, 6'd21, 6'd40:                           row = ROW_ST0;
      6'd1, 6'd22, 6'd41:                           row = ROW_ST1;
      6'd2, 6'd23:                                  row = ROW_BID;
      6'd42:                                        row = ROW_BIR;
      6'd8, 6'd29:                                  row = ROW_BRG;
      6'd14:                                        row = ROW_BDT;
      6'd3, 6'd9, 6'd15, 6'd24, 6'd30, 6'd43:       row = ROW_BHI;
      6'd4, 6'd10, 6'd16, 6'd25, 6'd31, 6'd44:      row = ROW_ALO;
      6'd5, 6'd11, 6'd17, 6'd26, 6'd32, 6'd45:      row = ROW_AHI;
      6'd6, 6'd7, 6'd12, 6'd13, 6'd27, 6'd28, 6'd33, 6'd34,
      6'd46, 6'd47, 6'd50, 6'd51, 6'd53:            row = ROW_GLO;
      6'd37, 6'd38, 6'd39, 6'd52:                   row = ROW_GHI;
      6'd48:                                        row = ROW_RLO;
      6'd49:                                        row = ROW_RHI;
      6'd18, 6'd35, 6'd54, 6'd55:                   row = ROW_SP0;
      6'd19, 6'd36, 6'd56:                          row = ROW_SP1;
      6'd20, 6'd57:                                 row = ROW_SP2;
      default:                                      row = ROW_GHI;
    endcase
    return row;
  endfunction

endpackage

FILE: sv/sccb_front.sv
// ----------------------------------------------------------------------------
// SCCB front end
// Accepts input items, classifies the opcode and queues them for the
// sequencer in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sccb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sccb_pkg::sccb_in_t   in_data,
  output logic                 q_valid,
  output sccb_pkg::sccb_cmd_t  q_item,
  input  logic                 q_pop
);

  sccb_pkg::sccb_cmd_t slots [sccb_pkg::QUEUE_DEPTH];
  sccb_pkg::sccb_cmd_t cmd;
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                push;

  // Classify the opcode; the reserved code becomes an item with no effect.
  always_comb begin
    cmd.reg_addr   = in_data.reg_addr;
    cmd.write_data = in_data.write_data;
    cmd.sda_in     = in_data.sda_in;
    unique case (in_data.opcode)
      sccb_pkg::OP_TICK:  cmd.kind = sccb_pkg::KIND_TICK;
      sccb_pkg::OP_WRITE: cmd.kind = sccb_pkg::KIND_WRITE;
      sccb_pkg::OP_READ:  cmd.kind = sccb_pkg::KIND_READ;
      default:            cmd.kind = sccb_pkg::KIND_NOP;
    endcase
  end

  assign in_ready = (count != 2'(sccb_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (q_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: sv/sccb_back.sv
// ----------------------------------------------------------------------------
// SCCB back end
// Bit-level sequencer: while the result register is not stalled, takes one
// queued item per cycle, steps the phase programme and registers a result for each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sccb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  sccb_pkg::sccb_cmd_t  q_item,
  output logic                 q_pop,
  input  logic [7:0]           device_address,
  input  logic [15:0]          phase_ticks,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sccb_pkg::sccb_out_t  out_data
);

  logic [5:0]  step;
  logic [15:0] phase_count;
  logic [3:0]  bit_count;
  logic [7:0]  shift_byte;
  logic [7:0]  held_register;
  logic [7:0]  held_data;
  logic        is_read;
  logic        error_flag;
  logic [7:0]  received_byte;
  logic [2:0]  lines;

  logic [5:0]  step_next;
  logic [15:0] phase_count_next;
  logic [3:0]  bit_count_next;
  logic [7:0]  shift_byte_next;
  logic [7:0]  held_register_next;
  logic [7:0]  held_data_next;
  logic        is_read_next;
  logic        error_flag_next;
  logic [7:0]  received_byte_next;
  logic [2:0]  lines_next;
  logic        done_next;

  sccb_pkg::phase_row_t cur_row;
  sccb_pkg::phase_row_t tgt_row;
  logic [16:0] tick_count;
  logic [16:0] tick_limit;
  logic [3:0]  bit_inc;
  logic [5:0]  target;
  logic        enter;
  logic        sda_level;

  // Take an item whenever the result register is free or being emptied.
  assign q_pop = q_valid && (!out_valid || out_ready);

  // Sequencer next state for the item at the head of the queue.
  always_comb begin
    step_next          = step;
    phase_count_next   = phase_count;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    held_register_next = held_register;
    held_data_next     = held_data;
    is_read_next       = is_read;
    error_flag_next    = error_flag;
    received_byte_next = received_byte;
    lines_next         = lines;
    done_next          = 1'b0;
    enter              = 1'b0;
    target             = step + 6'd1;
    cur_row            = sccb_pkg::phase_row(step);
    tick_count         = {1'b0, phase_count} + 17'd1;
    tick_limit         = (phase_ticks == 16'd0) ? 17'd1 : {1'b0, phase_ticks};
    bit_inc            = bit_count + 4'd1;

    if (step >= sccb_pkg::STEP_COUNT) begin
      // Idle: a command starts a transaction, anything else is dropped.
      if (q_item.kind == sccb_pkg::KIND_WRITE || q_item.kind == sccb_pkg::KIND_READ) begin
        held_register_next = q_item.reg_addr;
        held_data_next     = q_item.write_data;
        is_read_next       = (q_item.kind == sccb_pkg::KIND_READ);
        error_flag_next    = 1'b0;
        bit_count_next     = 4'd0;
        phase_count_next   = 16'd0;
        enter              = 1'b1;
        target             = (q_item.kind == sccb_pkg::KIND_READ) ?
                             sccb_pkg::STEP_READ : sccb_pkg::STEP_WRITE;
      end
    end else if (q_item.kind == sccb_pkg::KIND_TICK) begin
      if (tick_count < tick_limit) begin
        phase_count_next = tick_count[15:0];
      end else begin
        // End of phase: carry out its action, then move on.
        phase_count_next = 16'd0;
        unique case (cur_row.act)
          sccb_pkg::ACT_ACK: begin
            if (!is_read && q_item.sda_in) begin
              error_flag_next = 1'b1;
            end
          end
          sccb_pkg::ACT_SAMPLE: begin
            shift_byte_next = {shift_byte[6:0], q_item.sda_in};
          end
          sccb_pkg::ACT_LOOPW, sccb_pkg::ACT_LOOPR: begin
            if (cur_row.act == sccb_pkg::ACT_LOOPW) begin
              shift_byte_next = {shift_byte[6:0], 1'b0};
            end
            if (bit_inc < sccb_pkg::BITS_PER_BYTE) begin
              bit_count_next = bit_inc;
              target         = step - 6'd1;
            end else begin
              bit_count_next = 4'd0;
              if (cur_row.act == sccb_pkg::ACT_LOOPR) begin
                received_byte_next = shift_byte;
              end
            end
          end
          default: begin
          end
        endcase
        if (cur_row.act == sccb_pkg::ACT_FIN) begin
          step_next  = sccb_pkg::STEP_IDLE;
          lines_next = sccb_pkg::LINES_IDLE;
          done_next  = 1'b1;
        end else begin
          enter = 1'b1;
        end
      end
    end

    // Enter the target phase: load the shifter and set the line levels.
    tgt_row   = sccb_pkg::phase_row(target);
    sda_level = 1'b1;
    if (enter) begin
      step_next = target;
      if (tgt_row.load != sccb_pkg::LOAD_NONE && bit_count_next == 4'd0) begin
        unique case (tgt_row.load)
          sccb_pkg::LOAD_ID:   shift_byte_next = device_address;
          sccb_pkg::LOAD_IDR:  shift_byte_next = device_address | sccb_pkg::READ_BIT;
          sccb_pkg::LOAD_REG:  shift_byte_next = held_register_next;
          default:             shift_byte_next = held_data_next;
        endcase
      end
      unique case (tgt_row.sda)
        sccb_pkg::SDA_LO:  sda_level = 1'b0;
        sccb_pkg::SDA_BIT: sda_level = shift_byte_next[7];
        default:           sda_level = 1'b1;
      endcase
      lines_next = {tgt_row.scl, sda_level, tgt_row.oe};
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= sccb_pkg::STEP_IDLE;
      phase_count   <= 16'd0;
      bit_count     <= 4'd0;
      shift_byte    <= 8'd0;
      held_register <= 8'd0;
      held_data     <= 8'd0;
      is_read       <= 1'b0;
      error_flag    <= 1'b0;
      received_byte <= 8'd0;
      lines         <= sccb_pkg::LINES_IDLE;
    end else if (q_pop) begin
      step          <= step_next;
      phase_count   <= phase_count_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      held_register <= held_register_next;
      held_data     <= held_data_next;
      is_read       <= is_read_next;
      error_flag    <= error_flag_next;
      received_byte <= received_byte_next;
      lines         <= lines_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data.scl        <= lines_next[2];
      out_data.sda_out    <= lines_next[1];
      out_data.sda_enable <= lines_next[0];
      out_data.busy_res   <= (step_next < sccb_pkg::STEP_COUNT);
      out_data.done_res   <= done_next;
      out_data.ack_error  <= done_next & error_flag_next;
      out_data.read_data  <= received_byte_next;
    end
  end

endmodule

FILE: sv/sccb_master_register_access_unit.sv
// ----------------------------------------------------------------------------
// SCCB master register access unit
// Bit-level SCCB master: register write and register read transactions
// paced by tick items, with a line-level result for every item.
//
// Input channel in_valid/in_ready carries opcode, reg_addr, write_data and
// sda_in; output channel out_valid/out_ready returns one result per item.
// An accepted item is written into the queue, and the sequencer then
// registers its result in the result register. One item is taken every
// cycle while out_ready is high: a two-entry queue sits between the front
// end and the sequencer, and the sequencer retires one item per cycle into
// the result register, so ticks may stream back to back.
// When out_ready is low, the result register holds, the queue fills and
// in_ready drops once both entries are full.
// Configuration writes on cfg_valid/cfg_ready (always ready) set the device
// address and the phase length; write them only while no items are in flight.
// Reset clears the queue and sets both lines high and driven, with the
// device address at 66 and 50 ticks per phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sccb_master_register_access_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sccb_pkg::sccb_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sccb_pkg::sccb_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [7:0]          device_address;
  logic [15:0]         phase_ticks;
  logic                q_valid;
  logic                q_pop;
  sccb_pkg::sccb_cmd_t q_item;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= sccb_pkg::DEVICE_ADDRESS_RESET;
      phase_ticks    <= sccb_pkg::PHASE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sccb_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg_data[7:0];
        default:                      phase_ticks    <= cfg_data;
      endcase
    end
  end

  // Front end: accept, classify, queue.
  sccb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Back end: phase sequencer and result register.
  sccb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .device_address (device_address),
    .phase_ticks    (phase_ticks),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

  // A finished transaction leaves the block idle.
  `SCCB_ASSERT_IMPL(a_done_not_busy, clk, rst, out_valid && out_data.done_res, !out_data.busy_res, "done item still busy")
  // An acknowledge error is reported only with done.
  `SCCB_ASSERT_IMPL(a_error_with_done, clk, rst, out_valid && out_data.ack_error, out_data.done_res, "ack error without done")
  // An empty queue always has room for an item.
  `SCCB_ASSERT_IMPL(a_empty_queue_ready, clk, rst, !q_valid, in_ready, "empty queue refuses items")
  // The sequencer only takes items that the queue holds.
  `SCCB_ASSERT_IMPL(a_pop_needs_item, clk, rst, q_pop, q_valid, "pop from empty queue")

endmodule
